// ===== rtl/wnmm_pkg.sv =====
package wnmm_pkg;

   localparam int MaxWindow = 256;
   localparam int AddrWidth = $clog2(MaxWindow);
   localparam int CountWidth = AddrWidth + 1;
   localparam int SampleWidth = 16;
   localparam int LengthWidth = 9;
   localparam logic [LengthWidth-1:0] LengthReset = LengthWidth'(64);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INS_RD  = 6'b000010,
      ST_INS_CMP = 6'b000100,
      ST_FINISH  = 6'b001000,
      ST_MED     = 6'b010000,
      ST_EMIT    = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic ins_rd;
      logic ins_shift;
      logic ins_place;
      logic med_rd;
      logic emit;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic sample_zero;
      logic pos_zero;
      logic rdata_gt;
      logic window_full;
      logic rec_end;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/wnmm_req_if.sv =====
interface wnmm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample;
   logic        record_end;
   modport source (output valid, output sample, output record_end, input ready);
   modport sink (input valid, input sample, input record_end, output ready);
endinterface

// ===== rtl/wnmm_rsp_if.sv =====
interface wnmm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] window_median;
   logic [15:0] window_max;
   logic [8:0]  nonzero_count;
   modport source (output valid, output window_median, output window_max,
                   output nonzero_count, input ready);
   modport sink (input valid, input window_median, input window_max,
                 input nonzero_count, output ready);
endinterface

// ===== rtl/wnmm_csr_if.sv =====
interface wnmm_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/wnmm_ctrl.sv =====
module wnmm_ctrl
   import wnmm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_INS_RD;
            end
         end
         ST_INS_RD: begin
            if (status.sample_zero) begin
               state_in = ST_FINISH;
            end else if (status.pos_zero) begin
               cmd.ins_place = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            if (status.rdata_gt) begin
               cmd.ins_shift = 1'b1;
               state_in = ST_INS_RD;
            end else begin
               cmd.ins_place = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.window_full) begin
               cmd.med_rd = 1'b1;
               state_in = ST_MED;
            end else begin
               cmd.clear = status.rec_end;
               state_in = ST_IDLE;
            end
         end
         ST_MED: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state register not one-hot");
   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INS_CMP |-> $past(state_ff) == ST_INS_RD)
      else $error("compare without read");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("emit into busy output");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff != ST_IDLE)
      else $error("accept did not start work");
`endif

endmodule

// ===== rtl/wnmm_dp.sv =====
module wnmm_dp
   import wnmm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [SampleWidth-1:0] req_sample,
   input  logic                   req_record_end,
   input  logic                   csr_valid,
   input  logic [LengthWidth-1:0] csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_window_median,
   output logic [15:0]            rsp_window_max,
   output logic [8:0]             rsp_nonzero_count
);

   logic [SampleWidth-1:0] mem [MaxWindow];
   logic [SampleWidth-1:0] rdata_ff;
   logic [SampleWidth-1:0] sample_ff, max_ff;
   logic                   rec_end_ff;
   logic [LengthWidth-1:0] length_ff;
   logic [CountWidth-1:0]  zeros_ff, nz_ff, pos_ff;
   logic [CountWidth-1:0]  fill, eff_len, med_idx;
   logic                   rsp_valid_ff;
   logic [15:0]            med_out_ff, max_out_ff;
   logic [8:0]             cnt_out_ff;
   logic [AddrWidth-1:0]   wr_addr, rd_addr;
   logic                   wr_en, rd_en;
   logic [SampleWidth-1:0] wr_data;

   always_comb begin
      if (length_ff == '0) begin
         eff_len = CountWidth'(1);
      end else if (32'(length_ff) > MaxWindow) begin
         eff_len = CountWidth'(MaxWindow);
      end else begin
         eff_len = CountWidth'(length_ff);
      end
   end

   assign fill = zeros_ff + nz_ff;
   assign med_idx = nz_ff >> 1;
   assign wr_en = cmd.ins_shift | cmd.ins_place;
   assign wr_addr = pos_ff[AddrWidth-1:0];
   assign wr_data = cmd.ins_shift ? rdata_ff : sample_ff;
   assign rd_en = cmd.ins_rd | cmd.med_rd;
   assign rd_addr = cmd.med_rd ? med_idx[AddrWidth-1:0] : wr_addr - AddrWidth'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LengthReset;
         zeros_ff <= '0;
         nz_ff <= '0;
         max_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            length_ff <= csr_data;
         end
         if (cmd.load) begin
            sample_ff <= req_sample;
            rec_end_ff <= req_record_end;
            pos_ff <= nz_ff;
            if (req_sample == '0) begin
               zeros_ff <= zeros_ff + CountWidth'(1);
            end
            if (req_sample > max_ff) begin
               max_ff <= req_sample;
            end
         end
         if (cmd.ins_shift) begin
            pos_ff <= pos_ff - CountWidth'(1);
         end
         if (cmd.ins_place) begin
            nz_ff <= nz_ff + CountWidth'(1);
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
            med_out_ff <= (nz_ff == '0) ? '0 : rdata_ff;
            max_out_ff <= max_ff;
            cnt_out_ff <= 9'(nz_ff);
         end
         if (cmd.clear) begin
            zeros_ff <= '0;
            nz_ff <= '0;
            max_ff <= '0;
         end
      end
   end

   always_comb begin
      status.sample_zero = (sample_ff == '0);
      status.pos_zero = (pos_ff == '0);
      status.rdata_gt = (rdata_ff > sample_ff);
      status.window_full = (fill >= eff_len);
      status.rec_end = rec_end_ff;
      status.out_free = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_window_median = med_out_ff;
   assign rsp_window_max = max_out_ff;
   assign rsp_nonzero_count = cnt_out_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill) <= MaxWindow)
      else $error("window fill overflow");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> pos_ff <= nz_ff)
      else $error("insert position beyond sorted run");
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> zeros_ff == '0 && nz_ff == '0)
      else $error("window not cleared");
`endif

endmodule

// ===== rtl/window_nonzero_median_max.sv =====
// A zero sample is only counted, not stored; a nonzero sample walks the sorted run from
// its end, reading and shifting up each stored sample larger than it, then is written in place.
// A completing beat then reads the median and, once the output register is free, loads the result.
// One beat is taken at a time: req.ready is high only while the controller is idle.
// Reset (synchronous, active high) clears counts, maximum, output valid and
// sets the window length to 64; memory contents are not cleared.
module window_nonzero_median_max
   import wnmm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   wnmm_req_if.sink   req,
   wnmm_rsp_if.source rsp,
   wnmm_csr_if.sink   csr
);

   cmd_type    cmd;
   status_type status;

   assign csr.ready = 1'b1;

   wnmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wnmm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_sample        (req.sample),
      .req_record_end    (req.record_end),
      .csr_valid         (csr.valid),
      .csr_data          (csr.data),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_window_median (rsp.window_median),
      .rsp_window_max    (rsp.window_max),
      .rsp_nonzero_count (rsp.nonzero_count)
   );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   import wnmm_pkg::*;

   typedef struct {
      logic [15:0] median;
      logic [15:0] max;
      logic [8:0]  count;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   failed = 1'b0;
   int   windows_checked = 0;
   int   samples_sent = 0;
   int   rsp_hold = 0;

   window_result_type expected_windows[$];

   logic [LengthWidth-1:0] model_length;
   logic [15:0]            model_sorted[MaxWindow];
   int                     model_fill;

   wnmm_req_if req_bus ();
   wnmm_rsp_if rsp_bus ();
   wnmm_csr_if csr_bus ();

   window_nonzero_median_max dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source),
      .csr   (csr_bus.sink)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("window_nonzero_median_max test failed");
      $finish;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.sample = '0;
      req_bus.record_end = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
   end

   function automatic int effective_length();
      int len;
      len = model_length;
      if (len == 0) len = 1;
      if (len > MaxWindow) len = MaxWindow;
      return len;
   endfunction

   function automatic void predict_window(logic [15:0] sample, logic rec_end);
      int pos;
      int zeros;
      int nz;
      window_result_type r;
      pos = model_fill;
      if (pos < MaxWindow) begin
         while (pos > 0 && model_sorted[pos-1] > sample) begin
            model_sorted[pos] = model_sorted[pos-1];
            pos--;
         end
         model_sorted[pos] = sample;
         model_fill++;
      end
      if (model_fill >= effective_length()) begin
         zeros = 0;
         while (zeros < model_fill && model_sorted[zeros] == 0) zeros++;
         nz = model_fill - zeros;
         r.median = (nz > 0) ? model_sorted[zeros + nz/2] : 16'd0;
         r.max = model_sorted[model_fill-1];
         r.count = nz[8:0];
         expected_windows.push_back(r);
         model_fill = 0;
      end
      if (rec_end) model_fill = 0;
   endfunction

   function automatic int random_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_sample(logic [15:0] sample, logic rec_end);
      int gap;
      gap = random_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= sample;
      req_bus.record_end <= rec_end;
      do @(posedge clock); while (!req_bus.ready);
      predict_window(sample, rec_end);
      samples_sent++;
   endtask

   task automatic drain_windows();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      while (expected_windows.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (600) @(posedge clock);
   endtask

   task automatic write_length(logic [8:0] value);
      drain_windows();
      csr_bus.valid <= 1'b1;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      model_length = value;
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [15:0] random_sample();
      int p;
      p = $urandom_range(0, 9);
      if (p < 3) return 16'd0;
      if (p < 4) return 16'hFFFF;
      if (p < 6) return 16'($urandom_range(1, 20));
      return 16'($urandom);
   endfunction

   always @(posedge clock) begin
      window_result_type e;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_windows.size() == 0) begin
               $error("unexpected result beat: median %0d max %0d count %0d",
                      rsp_bus.window_median, rsp_bus.window_max, rsp_bus.nonzero_count);
               failed = 1'b1;
            end else begin
               e = expected_windows.pop_front();
               windows_checked++;
               if (rsp_bus.window_median !== e.median) begin
                  $error("window_median expected %0d actual %0d", e.median,
                         rsp_bus.window_median);
                  failed = 1'b1;
               end
               if (rsp_bus.window_max !== e.max) begin
                  $error("window_max expected %0d actual %0d", e.max, rsp_bus.window_max);
                  failed = 1'b1;
               end
               if (rsp_bus.nonzero_count !== e.count) begin
                  $error("nonzero_count expected %0d actual %0d", e.count,
                         rsp_bus.nonzero_count);
                  failed = 1'b1;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_hold = $urandom_range(8, 30);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) < 70);
         end
      end
   end

   task automatic test_short_windows();
      write_length(9'd1);
      send_sample(16'd0, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'd1, 1'b1);
      write_length(9'd0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'd0, 1'b1);
      write_length(9'd4);
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'd7, 1'b0);
      send_sample(16'd3, 1'b1);
      send_sample(16'd9, 1'b0);
      send_sample(16'd5, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(16'hFFFF, 1'b1);
      send_sample(16'h5555, 1'b0);
      send_sample(16'hAAAA, 1'b0);
      write_length(9'd2);
      send_sample(16'd2, 1'b0);
   endtask

   task automatic test_length_limits();
      write_length(9'd511);
      for (int i = 0; i < 260; i++) send_sample(random_sample(), i == 259);
      write_length(9'd256);
      for (int i = 0; i < 256; i++) send_sample(16'(255 - i), 1'b0);
   endtask

   task automatic test_random_records();
      int len;
      int n;
      while (samples_sent < 900) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 8);
         write_length(9'(len));
         for (int r = 0; r < 8; r++) begin
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++)
               send_sample(random_sample(), i == n - 1);
         end
      end
   endtask

   initial begin
      model_length = LengthReset;
      model_fill = 0;
      for (int i = 0; i < MaxWindow; i++) model_sorted[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 70; i++) send_sample(random_sample(), i == 69);
      test_short_windows();
      test_length_limits();
      test_random_records();
      drain_windows();
      $display("Sent %0d samples over window lengths 0 to 511 and checked %0d windows.",
               samples_sent, windows_checked);
      if (!failed && expected_windows.size() == 0) begin
         $display("window_nonzero_median_max test passed");
      end else begin
         $display("window_nonzero_median_max test failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/wnmm_pkg.sv
rtl/wnmm_req_if.sv
rtl/wnmm_rsp_if.sv
rtl/wnmm_csr_if.sv
rtl/wnmm_ctrl.sv
rtl/wnmm_dp.sv
rtl/window_nonzero_median_max.sv
tb/sv/tb.sv
